/* design/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int OPCODE_BITS = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_PURGE  = 2'd3
    } spq_op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } spq_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_RD,
        S_REM_CAP,
        S_RD_FRONT,
        S_RD_TAIL,
        S_CAP_TAIL,
        S_DONE
    } spq_state_t;

endpackage

/* design/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/sorted_priority_queue.sv */
// Sorted priority queue: one RAM ring kept in rank order, walked by a small sequencer.
// An insert walks back from the tail through the one read port, moving each entry of lower
// rank back one place until it meets one of greater or equal rank, then writes the new word
// behind it, or at the front; every operation then reads the front and tail of a non-empty queue.
// s_tready is high only in idle, so a new word is taken only once the last result is loaded.
// Reset (synchronous, aresetn low) empties the queue and drops any pending result word.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int RANK_BITS    = 16,
    parameter int PAYLOAD_BITS = 32,
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW          = $clog2(DEPTH + 1),
    localparam int ITEM_W      = RANK_BITS + PAYLOAD_BITS,
    localparam int S_DATA_W    = ((ITEM_W + 7) / 8) * 8,
    localparam int M_FIELDS_W  = 3 * ITEM_W + CW,
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // item_rank, item_payload (from bit 0 up), zero padded
    input  logic [S_DATA_W-1:0]   s_tdata,
    // opcode
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // removed_rank, removed_payload, front_rank, front_payload,
    // tail_rank, tail_payload, entry_count (from bit 0 up), zero padded
    output logic [M_DATA_W-1:0]   m_tdata,
    // status, is_empty (from bit 0 up)
    output logic [2:0]            m_tuser
);

    spq_state_t state_reg, state_next;

    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           head_reg;
    logic [AW-1:0]           idx_reg;
    logic [RANK_BITS-1:0]    rank_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    spq_status_t             status_reg;
    logic [ITEM_W-1:0]       removed_reg;
    logic [ITEM_W-1:0]       front_reg;
    logic [ITEM_W-1:0]       tail_reg;
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;
    logic [2:0]              m_tuser_reg;

    logic                    ram_we;
    logic                    wr_new;
    logic [AW-1:0]           rd_log;
    logic [AW-1:0]           wr_log;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [ITEM_W-1:0]       wr_data;
    logic [ITEM_W-1:0]       rd_data;
    logic                    ready_int;
    logic                    out_load;
    logic                    accept;
    logic                    rank_ge;
    logic                    is_full;
    logic                    is_zero;
    logic [CW-1:0]           count_dec;
    logic [AW-1:0]           tail_log;
    logic [AW-1:0]           idx_inc;
    spq_op_t                 s_op;

    // Map a position in the sorted order to a RAM address around the ring
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign s_op      = spq_op_t'(s_tuser);
    assign accept    = s_tvalid && ready_int;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_zero   = (count_reg == '0);
    assign count_dec = count_reg - CW'(1);
    assign tail_log  = count_dec[AW-1:0];
    assign idx_inc   = idx_reg + AW'(1);
    assign rank_ge   = (rd_data[ITEM_W-1:PAYLOAD_BITS] >= rank_reg);
    assign rd_addr   = ring_addr(head_reg, rd_log);
    assign wr_addr   = ring_addr(head_reg, wr_log);
    assign wr_data   = wr_new ? {rank_reg, payload_reg} : rd_data;

    spq_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_INSERT: begin
                            if (is_full) begin
                                state_next = S_RD_FRONT;
                            end else if (is_zero) begin
                                state_next = S_INS_PUT;
                            end else begin
                                state_next = S_INS_RD;
                            end
                        end
                        OP_REMOVE: state_next = is_zero ? S_RD_FRONT : S_REM_RD;
                        OP_PEEK:   state_next = S_RD_FRONT;
                        OP_PURGE:  state_next = S_RD_FRONT;
                        default:   state_next = S_RD_FRONT;
                    endcase
                end
            end
            S_INS_RD:  state_next = S_INS_CMP;
            S_INS_CMP: begin
                if (rank_ge) begin
                    state_next = S_RD_FRONT;
                end else if (idx_reg == '0) begin
                    state_next = S_INS_PUT;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_PUT:  state_next = S_RD_FRONT;
            S_REM_RD:   state_next = S_REM_CAP;
            S_REM_CAP:  state_next = S_RD_FRONT;
            S_RD_FRONT: state_next = is_zero ? S_DONE : S_RD_TAIL;
            S_RD_TAIL:  state_next = S_CAP_TAIL;
            S_CAP_TAIL: state_next = S_DONE;
            S_DONE:     state_next = out_load ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: RAM port control and handshakes
    always_comb begin
        rd_log    = '0;
        wr_log    = '0;
        ram_we    = 1'b0;
        wr_new    = 1'b0;
        ready_int = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:    ready_int = 1'b1;
            S_INS_RD:  rd_log = idx_reg;
            S_INS_CMP: begin
                // place the new word behind, or move the smaller one back
                ram_we = 1'b1;
                wr_log = idx_inc;
                wr_new = rank_ge;
            end
            S_INS_PUT: begin
                ram_we = 1'b1;
                wr_log = idx_reg;
                wr_new = 1'b1;
            end
            S_REM_RD:   rd_log = '0;
            S_RD_FRONT: rd_log = '0;
            S_RD_TAIL:  rd_log = tail_log;
            S_DONE:     out_load = !m_valid_reg || m_tready;
            default: begin
                rd_log = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_op == OP_PURGE) begin
                count_reg <= '0;
            end
            if ((state_reg == S_INS_CMP && rank_ge) || state_reg == S_INS_PUT) begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == S_REM_CAP) begin
                count_reg <= count_dec;
                head_reg  <= ring_addr(head_reg, AW'(1));
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result data registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            rank_reg    <= s_tdata[RANK_BITS-1:0];
            payload_reg <= s_tdata[ITEM_W-1:RANK_BITS];
            removed_reg <= '0;
            idx_reg     <= is_zero ? '0 : tail_log;
            status_reg  <= STAT_OK;
            if (s_op == OP_INSERT && is_full) begin
                status_reg <= STAT_FULL;
            end
            if (s_op == OP_REMOVE && is_zero) begin
                status_reg <= STAT_EMPTY;
            end
        end
        if (state_reg == S_INS_CMP && !rank_ge && idx_reg != '0) begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (state_reg == S_REM_CAP) begin
            removed_reg <= rd_data;
        end
        if (state_reg == S_RD_FRONT && is_zero) begin
            front_reg <= '0;
            tail_reg  <= '0;
        end
        if (state_reg == S_RD_TAIL) begin
            front_reg <= rd_data;
        end
        if (state_reg == S_CAP_TAIL) begin
            tail_reg <= rd_data;
        end
        if (out_load) begin
            m_tdata_reg <= M_DATA_W'({
                count_reg,
                tail_reg[PAYLOAD_BITS-1:0], tail_reg[ITEM_W-1:PAYLOAD_BITS],
                front_reg[PAYLOAD_BITS-1:0], front_reg[ITEM_W-1:PAYLOAD_BITS],
                removed_reg[PAYLOAD_BITS-1:0], removed_reg[ITEM_W-1:PAYLOAD_BITS]
            });
            m_tuser_reg <= {is_zero, status_reg};
        end
    end

    assign s_tready = ready_int;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* test/testbench.sv */
// Self-checking stream testbench for the sorted priority queue.
module testbench;
    import spq_pkg::*;

    localparam int Q_DEPTH   = 16;
    localparam int RANDOM_N  = 2000;
    localparam int S_W       = 48;
    localparam int M_W       = 152;

    typedef struct {
        spq_op_t     op;
        logic [15:0] rank;
        logic [31:0] payload;
        int          gap;
        bit          hold_drain;
    } op_word_t;

    typedef struct packed {
        spq_status_t status;
        logic [15:0] removed_rank;
        logic [31:0] removed_payload;
        logic [15:0] front_rank;
        logic [31:0] front_payload;
        logic [15:0] tail_rank;
        logic [31:0] tail_payload;
        logic [4:0]  entry_count;
        logic        is_empty;
    } outcome_t;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [S_W-1:0]  s_tdata;
    logic [1:0]      s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [M_W-1:0]  m_tdata;
    logic [2:0]      m_tuser;

    op_word_t    op_words_q[$];
    outcome_t    outcome_q[$];
    logic [15:0] held_rank[Q_DEPTH];
    logic [31:0] held_payload[Q_DEPTH];
    int          held_count;
    int          queued_words;
    int          error_count;
    int          gap_left;
    int          calm_left;
    int          rx_left;
    bit          word_taken;

    sorted_priority_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the mirrored queue and return the expected result word
    function automatic outcome_t predict_outcome(spq_op_t op, logic [15:0] rank,
                                                 logic [31:0] payload);
        outcome_t o;
        int       pos;
        int       i;
        o = '0;
        o.status = STAT_OK;
        case (op)
            OP_INSERT: begin
                if (held_count >= Q_DEPTH) begin
                    o.status = STAT_FULL;
                end else begin
                    // place behind every entry of greater or equal rank
                    pos = 0;
                    while (pos < held_count && held_rank[pos] >= rank) pos++;
                    for (i = held_count; i > pos; i--) begin
                        held_rank[i]    = held_rank[i-1];
                        held_payload[i] = held_payload[i-1];
                    end
                    held_rank[pos]    = rank;
                    held_payload[pos] = payload;
                    held_count++;
                end
            end
            OP_REMOVE: begin
                if (held_count == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    o.removed_rank    = held_rank[0];
                    o.removed_payload = held_payload[0];
                    for (i = 1; i < held_count; i++) begin
                        held_rank[i-1]    = held_rank[i];
                        held_payload[i-1] = held_payload[i];
                    end
                    held_count--;
                end
            end
            OP_PURGE: held_count = 0;
            default: ;
        endcase
        if (held_count > 0) begin
            o.front_rank    = held_rank[0];
            o.front_payload = held_payload[0];
            o.tail_rank     = held_rank[held_count-1];
            o.tail_payload  = held_payload[held_count-1];
        end
        o.entry_count = 5'(held_count);
        o.is_empty    = (held_count == 0);
        return o;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // Sender gaps: mostly short, a few long, with stretches of none
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(30, 150);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Ranks: narrow bands for ties, full range, and the extremes
    function automatic logic [15:0] pick_rank();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom_range(100, 104));
        if (r < 8) return 16'($urandom);
        if (r == 8) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'hFFFF - 16'($urandom_range(0, 3));
    endfunction

    task automatic queue_word(spq_op_t op, logic [15:0] rank, logic [31:0] payload,
                              bit hold_drain);
        op_word_t w;
        w.op         = op;
        w.rank       = rank;
        w.payload    = payload;
        w.gap        = pick_gap();
        w.hold_drain = hold_drain;
        op_words_q.push_back(w);
        queued_words++;
    endtask

    task automatic queue_random_op(spq_op_t op);
        queue_word(op, pick_rank(), 32'($urandom), ($urandom_range(0, 149) == 0));
    endtask

    // Sender: at a falling edge, present the next word once its gap and any drain hold are over
    always @(negedge aclk) begin
        op_word_t w;
        bit       drive;
        drive = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (op_words_q.size() > 0) begin
                if (gap_left < 0) gap_left = op_words_q[0].gap;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!op_words_q[0].hold_drain || outcome_q.size() == 0) begin
                    w = op_words_q.pop_front();
                    s_tdata  <= {w.payload, w.rank};
                    s_tuser  <= w.op;
                    drive    = 1'b1;
                    gap_left = -1;
                end
            end
            s_tvalid <= drive;
        end
    end

    // Receiver: ready runs and stalls of random length
    always @(negedge aclk) begin
        int r;
        if (rx_left > 0) begin
            rx_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                m_tready <= 1'b1;
                rx_left = $urandom_range(100, 300);
            end else if (r < 50) begin
                m_tready <= 1'b1;
                rx_left = $urandom_range(0, 20);
            end else if (r < 92) begin
                m_tready <= 1'b0;
                rx_left = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                rx_left = $urandom_range(10, 40);
            end
        end
    end

    // Check result words first, then record what each accepted word should produce
    always @(posedge aclk) begin
        outcome_t want;
        word_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                check_field("status",          want.status,       m_tuser[1:0]);
                check_field("is_empty",        want.is_empty,     m_tuser[2]);
                check_field("removed_rank",    want.removed_rank,    m_tdata[15:0]);
                check_field("removed_payload", want.removed_payload, m_tdata[47:16]);
                check_field("front_rank",      want.front_rank,      m_tdata[63:48]);
                check_field("front_payload",   want.front_payload,   m_tdata[95:64]);
                check_field("tail_rank",       want.tail_rank,       m_tdata[111:96]);
                check_field("tail_payload",    want.tail_payload,    m_tdata[143:112]);
                check_field("entry_count",     want.entry_count,     m_tdata[148:144]);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            outcome_q.push_back(predict_outcome(spq_op_t'(s_tuser), s_tdata[15:0],
                                                s_tdata[47:16]));
        end
    end

    initial begin
        int kind;
        int len;
        int r;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_PEEK;
        m_tready     = 1'b0;
        word_taken   = 1'b0;
        held_count   = 0;
        queued_words = 0;
        error_count  = 0;
        gap_left     = -1;
        calm_left    = 0;
        rx_left      = 0;

        // Directed: empty-queue cases, extremes, ties at front, middle and tail, full
        queue_word(OP_PEEK,   16'h1234, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_REMOVE, 16'hFFFF, 32'hA5A5_A5A5, 1'b0);
        queue_word(OP_PURGE,  16'h0000, 32'h0000_0000, 1'b0);
        queue_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_INSERT, 16'h0000, 32'h0000_0000, 1'b0);
        queue_word(OP_INSERT, 16'h0000, 32'h1234_5678, 1'b0);
        queue_word(OP_INSERT, 16'h8000, 32'h0000_000A, 1'b0);
        queue_word(OP_INSERT, 16'h8000, 32'h0000_000B, 1'b0);
        queue_word(OP_INSERT, 16'hFFFF, 32'h0000_0001, 1'b0);
        queue_word(OP_PEEK,   16'h5555, 32'h5555_5555, 1'b0);
        queue_word(OP_REMOVE, 16'hAAAA, 32'hAAAA_AAAA, 1'b0);
        repeat (11) queue_word(OP_INSERT, pick_rank(), 32'($urandom), 1'b0);
        queue_word(OP_INSERT, 16'h7FFF, 32'hDEAD_BEEF, 1'b1);
        queue_word(OP_PEEK,   16'h0000, 32'h0000_0000, 1'b0);
        queue_word(OP_PURGE,  16'hFFFF, 32'hFFFF_FFFF, 1'b0);

        // Random: fill and drain runs with random content, mixed traffic, rare purges
        queued_words = 0;
        while (queued_words < RANDOM_N) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 20);
            if (kind < 30) begin
                repeat (len) queue_random_op(OP_INSERT);
            end else if (kind < 55) begin
                repeat (len) queue_random_op(OP_REMOVE);
            end else if (kind < 96) begin
                repeat (2 * len) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)      queue_random_op(OP_INSERT);
                    else if (r < 85) queue_random_op(OP_REMOVE);
                    else if (r < 97) queue_random_op(OP_PEEK);
                    else             queue_random_op(OP_PURGE);
                end
            end else begin
                queue_random_op(OP_PURGE);
            end
        end

        // Hold reset, then release it at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain every word and every expected result, then let the pipeline settle
        while (op_words_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("sorted_priority_queue test passed");
        end else begin
            $display("sorted_priority_queue test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("sorted_priority_queue test failed");
        $finish;
    end

endmodule
